>>> hw/rtl/double_ended_queue_unit_defines.svh
// Assertion macros for the double-ended queue unit checker.
// Depends on nothing; users must have clk and rst_n in scope.
`ifndef DOUBLE_ENDED_QUEUE_UNIT_DEFINES_SVH
`define DOUBLE_ENDED_QUEUE_UNIT_DEFINES_SVH

// same-cycle implication, disabled in reset
`define DEQ_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled in reset
`define DEQ_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hw/rtl/deq_pkg.sv
// Shared types and codes for the double-ended queue unit.
// No dependencies.
package deq_pkg;

  localparam int OPCODE_W = 3;
  localparam int VALUE_W  = 32;
  localparam int STATUS_W = 2;

  typedef enum logic [OPCODE_W-1:0] {
    OP_PUSH_FRONT = 3'd0,
    OP_PUSH_BACK  = 3'd1,
    OP_POP_FRONT  = 3'd2,
    OP_POP_BACK   = 3'd3,
    OP_PEEK_FRONT = 3'd4,
    OP_PEEK_BACK  = 3'd5,
    OP_CLEAR      = 3'd6
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_VALUE = 2'd1,
    ST_EMPTY = 2'd2,
    ST_FULL  = 2'd3
  } status_t;

  // chain movement: UP = cell i takes cell i-1, DN = cell i takes cell i+1 (ring wrap)
  typedef enum logic [1:0] {
    MV_HOLD = 2'd0,
    MV_UP   = 2'd1,
    MV_DN   = 2'd2
  } move_t;

  typedef struct packed {
    move_t move;
    logic  wr_en;
  } cell_ctl_t;

endpackage

>>> hw/rtl/deq_if.sv
// Command and response channel interfaces for the double-ended queue unit.
// Depends on deq_pkg.
interface deq_cmd_if;
  import deq_pkg::*;
  logic                valid;
  logic                ready;
  logic [OPCODE_W-1:0] opcode;
  logic [VALUE_W-1:0]  push_value;

  modport source (output valid, output opcode, output push_value, input ready);
  modport sink   (input valid, input opcode, input push_value, output ready);
endinterface

interface deq_rsp_if;
  import deq_pkg::*;
  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [VALUE_W-1:0]  read_value;

  modport source (output valid, output status, output read_value, input ready);
  modport sink   (input valid, input status, input read_value, output ready);
endinterface

>>> hw/rtl/double_ended_queue_unit.sv
// The result is registered for the next cycle when the addressed end is anchored
// (pushes, clear, front reads in front layout, back reads in back layout); otherwise
// the cell ring first rotates by min(n, DEPTH-n) positions, n = occupancy.
// Throughput: one command per cycle while no rotation runs and no result is stalled.
// Reset clears occupancy, anchor mode and control; cell contents are not reset.
// Depends on deq_pkg, deq_if, deq_cell and deq_ctrl.
module double_ended_queue_unit #(
  parameter int DEPTH      = 16,
  parameter int DATA_WIDTH = 32
) (
  input  logic      clk,
  input  logic      rst_n,
  deq_cmd_if.sink   in_cmd,
  deq_rsp_if.source out_rsp
);
  import deq_pkg::*;

  localparam int IDX_W = $clog2(DEPTH);

  logic [DATA_WIDTH-1:0] cell_word [DEPTH];
  cell_ctl_t             ctl;
  logic [IDX_W-1:0]      wr_idx;
  logic [DATA_WIDTH-1:0] wr_word;

  deq_ctrl #(
    .DEPTH      (DEPTH),
    .DATA_WIDTH (DATA_WIDTH),
    .IDX_W      (IDX_W)
  ) u_ctrl (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_cmd.valid),
    .in_ready       (in_cmd.ready),
    .in_opcode      (in_cmd.opcode),
    .in_push_value  (in_cmd.push_value),
    .out_valid      (out_rsp.valid),
    .out_ready      (out_rsp.ready),
    .out_status     (out_rsp.status),
    .out_read_value (out_rsp.read_value),
    .first_word     (cell_word[0]),
    .last_word      (cell_word[DEPTH-1]),
    .ctl            (ctl),
    .wr_idx         (wr_idx),
    .wr_word        (wr_word)
  );

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic sel;
    assign sel = ctl.wr_en && (wr_idx == IDX_W'(i));

    deq_cell #(
      .DATA_WIDTH (DATA_WIDTH)
    ) u_cell (
      .clk        (clk),
      .move       (ctl.move),
      .load       (sel),
      .load_word  (wr_word),
      .lower_word (cell_word[(i + DEPTH - 1) % DEPTH]),
      .upper_word (cell_word[(i + 1) % DEPTH]),
      .word       (cell_word[i])
    );
  end

endmodule

>>> hw/rtl/deq_cell.sv
// One storage cell of the queue chain: holds a word, loads, or takes a neighbor.
// Depends on deq_pkg.
module deq_cell #(
  parameter int DATA_WIDTH = 32
) (
  input  logic                  clk,
  input  deq_pkg::move_t        move,
  input  logic                  load,
  input  logic [DATA_WIDTH-1:0] load_word,
  input  logic [DATA_WIDTH-1:0] lower_word,
  input  logic [DATA_WIDTH-1:0] upper_word,
  output logic [DATA_WIDTH-1:0] word
);
  import deq_pkg::*;

  logic [DATA_WIDTH-1:0] word_r;
  logic [DATA_WIDTH-1:0] word_nxt;

  always_comb begin
    if (load) begin
      word_nxt = load_word;
    end else begin
      case (move)
        MV_UP:   word_nxt = lower_word;
        MV_DN:   word_nxt = upper_word;
        default: word_nxt = word_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    word_r <= word_nxt;
  end

  assign word = word_r;

endmodule

>>> hw/rtl/deq_ctrl.sv
// Queue controller: occupancy, anchor mode, chain rotation and result register.
// Depends on deq_pkg; drives the deq_cell chain.
module deq_ctrl #(
  parameter int DEPTH      = 16,
  parameter int DATA_WIDTH = 32,
  parameter int IDX_W      = 4
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [deq_pkg::OPCODE_W-1:0]   in_opcode,
  input  logic [deq_pkg::VALUE_W-1:0]    in_push_value,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [deq_pkg::STATUS_W-1:0]   out_status,
  output logic [deq_pkg::VALUE_W-1:0]    out_read_value,
  input  logic [DATA_WIDTH-1:0]          first_word,
  input  logic [DATA_WIDTH-1:0]          last_word,
  output deq_pkg::cell_ctl_t             ctl,
  output logic [IDX_W-1:0]               wr_idx,
  output logic [DATA_WIDTH-1:0]          wr_word
);
  import deq_pkg::*;

  localparam int             CNT_W   = $clog2(DEPTH + 1);
  localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(DEPTH);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(DEPTH - 1);

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_ROT  = 2'b10
  } state_t;

  function automatic logic is_back_read(input logic [OPCODE_W-1:0] op);
    return (op == OP_POP_BACK) || (op == OP_PEEK_BACK);
  endfunction

  function automatic logic is_read(input logic [OPCODE_W-1:0] op);
    return (op == OP_POP_FRONT) || (op == OP_PEEK_FRONT) ||
           (op == OP_POP_BACK)  || (op == OP_PEEK_BACK);
  endfunction

  state_t                state_r, state_nxt;
  logic [CNT_W-1:0]      cnt_r, cnt_nxt;
  logic                  back_mode_r, back_mode_nxt;   // 1: back word sits in last cell
  logic [CNT_W-1:0]      rot_r, rot_nxt;
  move_t                 rot_dir_r, rot_dir_nxt;
  logic [OPCODE_W-1:0]   cmd_op_r, cmd_op_nxt;
  logic                  out_valid_r, out_valid_nxt;
  logic [STATUS_W-1:0]   out_status_r, out_status_nxt;
  logic [VALUE_W-1:0]    out_value_r, out_value_nxt;

  logic                  acc;
  logic [CNT_W-1:0]      rem;
  logic                  near_front;
  logic [CNT_W-1:0]      steps;
  logic                  need_rot;
  logic                  exec_go;
  logic [OPCODE_W-1:0]   exec_op;
  logic                  mode_eff;
  logic [CNT_W-1:0]      back_slot;
  logic [CNT_W-1:0]      front_slot;
  logic [63:0]           push_ext;
  logic [63:0]           first_ext;
  logic [63:0]           last_ext;
  status_t               exec_status;
  logic [VALUE_W-1:0]    exec_value;

  assign in_ready = (state_r == ST_IDLE) && (!out_valid_r || out_ready);
  assign acc      = in_valid && in_ready;

  // shortest rotation between the two anchor layouts
  assign rem        = DEPTH_C - cnt_r;
  assign near_front = (cnt_r <= rem);
  assign steps      = near_front ? cnt_r : rem;
  assign need_rot   = is_read(in_opcode) && (cnt_r != '0) &&
                      (is_back_read(in_opcode) != back_mode_r) && (steps != '0);

  assign exec_op  = (state_r == ST_ROT) ? cmd_op_r : in_opcode;
  assign exec_go  = ((state_r == ST_IDLE) && acc && !need_rot) ||
                    ((state_r == ST_ROT) && (rot_r == '0));
  assign mode_eff = is_read(exec_op) ? is_back_read(exec_op) : back_mode_r;

  assign back_slot  = cnt_r;
  assign front_slot = DEPTH_C - cnt_r - CNT_W'(1);
  assign push_ext   = 64'(in_push_value);
  assign first_ext  = 64'(first_word);
  assign last_ext   = 64'(last_word);
  assign wr_word    = push_ext[DATA_WIDTH-1:0];

  always_comb begin
    state_nxt      = state_r;
    cnt_nxt        = cnt_r;
    back_mode_nxt  = back_mode_r;
    rot_nxt        = rot_r;
    rot_dir_nxt    = rot_dir_r;
    cmd_op_nxt     = cmd_op_r;
    out_valid_nxt  = out_valid_r && !out_ready;
    out_status_nxt = out_status_r;
    out_value_nxt  = out_value_r;
    ctl.move       = MV_HOLD;
    ctl.wr_en      = 1'b0;
    wr_idx         = '0;
    exec_status    = ST_OK;
    exec_value     = '0;

    if ((state_r == ST_IDLE) && acc && need_rot) begin
      state_nxt  = ST_ROT;
      rot_nxt    = steps;
      cmd_op_nxt = in_opcode;
      if (near_front) begin
        rot_dir_nxt = is_back_read(in_opcode) ? MV_DN : MV_UP;
      end else begin
        rot_dir_nxt = is_back_read(in_opcode) ? MV_UP : MV_DN;
      end
    end

    if ((state_r == ST_ROT) && (rot_r != '0)) begin
      ctl.move = rot_dir_r;
      rot_nxt  = rot_r - CNT_W'(1);
    end

    if (exec_go) begin
      state_nxt     = ST_IDLE;
      back_mode_nxt = mode_eff;
      case (exec_op)
        OP_PUSH_FRONT: begin
          if (cnt_r == DEPTH_C) begin
            exec_status = ST_FULL;
          end else begin
            cnt_nxt   = cnt_r + CNT_W'(1);
            ctl.wr_en = 1'b1;
            if (!mode_eff) begin
              ctl.move = MV_UP;
              wr_idx   = '0;
            end else begin
              wr_idx = front_slot[IDX_W-1:0];
            end
          end
        end
        OP_PUSH_BACK: begin
          if (cnt_r == DEPTH_C) begin
            exec_status = ST_FULL;
          end else begin
            cnt_nxt   = cnt_r + CNT_W'(1);
            ctl.wr_en = 1'b1;
            if (mode_eff) begin
              ctl.move = MV_DN;
              wr_idx   = LAST_IDX;
            end else begin
              wr_idx = back_slot[IDX_W-1:0];
            end
          end
        end
        OP_POP_FRONT, OP_PEEK_FRONT: begin
          if (cnt_r == '0) begin
            exec_status = ST_EMPTY;
          end else begin
            exec_status = ST_VALUE;
            exec_value  = first_ext[VALUE_W-1:0];
            if (exec_op == OP_POP_FRONT) begin
              ctl.move = MV_DN;
              cnt_nxt  = cnt_r - CNT_W'(1);
            end
          end
        end
        OP_POP_BACK, OP_PEEK_BACK: begin
          if (cnt_r == '0) begin
            exec_status = ST_EMPTY;
          end else begin
            exec_status = ST_VALUE;
            exec_value  = last_ext[VALUE_W-1:0];
            if (exec_op == OP_POP_BACK) begin
              ctl.move = MV_UP;
              cnt_nxt  = cnt_r - CNT_W'(1);
            end
          end
        end
        OP_CLEAR: begin
          cnt_nxt       = '0;
          back_mode_nxt = 1'b0;
        end
        default: begin
        end
      endcase
      out_valid_nxt  = 1'b1;
      out_status_nxt = exec_status;
      out_value_nxt  = exec_value;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      back_mode_r <= 1'b0;
      rot_r       <= '0;
      rot_dir_r   <= MV_HOLD;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      back_mode_r <= back_mode_nxt;
      rot_r       <= rot_nxt;
      rot_dir_r   <= rot_dir_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_op_r     <= cmd_op_nxt;
    out_status_r <= out_status_nxt;
    out_value_r  <= out_value_nxt;
  end

  assign out_valid      = out_valid_r;
  assign out_status     = out_status_r;
  assign out_read_value = out_value_r;

endmodule

>>> hw/rtl/deq_checker.sv
// Port-level checks for the double-ended queue unit, bound to the top level.
// Depends on deq_pkg and double_ended_queue_unit_defines.svh.
`include "double_ended_queue_unit_defines.svh"

module deq_checker (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         in_valid,
  input logic                         in_ready,
  input logic [deq_pkg::OPCODE_W-1:0] in_opcode,
  input logic                         out_valid,
  input logic                         out_ready,
  input logic [deq_pkg::STATUS_W-1:0] out_status,
  input logic [deq_pkg::VALUE_W-1:0]  out_read_value
);
  import deq_pkg::*;

  logic in_beat;
  logic anchored_op;

  assign in_beat     = in_valid && in_ready;
  assign anchored_op = (in_opcode == OP_PUSH_FRONT) || (in_opcode == OP_PUSH_BACK) ||
                       (in_opcode == OP_CLEAR);

  `DEQ_ASSERT_SAME(a_value_only_on_read, out_valid && (out_status != ST_VALUE), out_read_value == '0, "read_value nonzero without a returned word")
  `DEQ_ASSERT_SAME(a_one_outstanding, out_valid && !out_ready, !in_ready, "command taken while a result is stalled")
  `DEQ_ASSERT_NEXT(a_push_clear_next, in_beat && anchored_op, out_valid, "push or clear result not presented next cycle")
  `DEQ_ASSERT_NEXT(a_stall_holds, out_valid && !out_ready, out_valid && $stable(out_status) && $stable(out_read_value), "stalled result changed")

endmodule

bind double_ended_queue_unit deq_checker u_deq_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_cmd.valid),
  .in_ready       (in_cmd.ready),
  .in_opcode      (in_cmd.opcode),
  .out_valid      (out_rsp.valid),
  .out_ready      (out_rsp.ready),
  .out_status     (out_rsp.status),
  .out_read_value (out_rsp.read_value)
);

>>> tb/double_ended_queue_unit_checker.sv
// Scoreboard for the double-ended queue unit: watches command and result beats,
// predicts each result from its own ring model and compares field by field.
// Depends on deq_pkg.
module double_ended_queue_unit_checker #(
  parameter int DEPTH      = 16,
  parameter int DATA_WIDTH = 32
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cmd_valid,
  input  logic                         cmd_ready,
  input  logic [deq_pkg::OPCODE_W-1:0] cmd_opcode,
  input  logic [deq_pkg::VALUE_W-1:0]  cmd_push_value,
  input  logic                         rsp_valid,
  input  logic                         rsp_ready,
  input  logic [deq_pkg::STATUS_W-1:0] rsp_status,
  input  logic [deq_pkg::VALUE_W-1:0]  rsp_read_value,
  output int                           fail_cnt,
  output int                           pending_cnt,
  output int                           checked_cnt,
  output int                           full_cnt,
  output int                           empty_cnt
);
  timeunit 1ns;
  timeprecision 1ps;
  import deq_pkg::*;

  typedef struct packed {
    status_t            status;
    logic [VALUE_W-1:0] read_value;
  } deq_result_t;

  deq_result_t           result_q[$];
  logic [DATA_WIDTH-1:0] ring_words [DEPTH];
  int                    head_slot;
  int                    word_count;
  int                    fails;
  int                    checked;
  int                    fulls;
  int                    empties;

  // Applies one command to the shadow ring and returns the result it must produce.
  function automatic deq_result_t apply_cmd(logic [OPCODE_W-1:0] op,
                                            logic [VALUE_W-1:0] word);
    deq_result_t res;
    int          slot;
    res.status     = ST_OK;
    res.read_value = '0;
    case (op)
      OP_PUSH_FRONT, OP_PUSH_BACK: begin
        if (word_count == DEPTH) begin
          res.status = ST_FULL;
        end else begin
          if (op == OP_PUSH_FRONT) begin
            head_slot = (head_slot + DEPTH - 1) % DEPTH;
            slot      = head_slot;
          end else begin
            slot = (head_slot + word_count) % DEPTH;
          end
          ring_words[slot] = word[DATA_WIDTH-1:0];
          word_count++;
        end
      end
      OP_POP_FRONT, OP_POP_BACK, OP_PEEK_FRONT, OP_PEEK_BACK: begin
        if (word_count == 0) begin
          res.status = ST_EMPTY;
        end else begin
          if (op == OP_POP_FRONT || op == OP_PEEK_FRONT) slot = head_slot;
          else slot = (head_slot + word_count - 1) % DEPTH;
          res.status     = ST_VALUE;
          res.read_value = VALUE_W'(ring_words[slot]);
          if (op == OP_POP_FRONT) begin
            head_slot = (head_slot + 1) % DEPTH;
            word_count--;
          end else if (op == OP_POP_BACK) begin
            word_count--;
          end
        end
      end
      OP_CLEAR: begin
        head_slot  = 0;
        word_count = 0;
      end
      default: ; // unused opcode: no effect, plain ok
    endcase
    return res;
  endfunction

  always @(posedge clk) begin : watch
    deq_result_t want;
    if (!rst_n) begin
      result_q.delete();
      head_slot  = 0;
      word_count = 0;
    end else begin
      // result first: a result can never answer a command taken on the same edge
      if (rsp_valid && rsp_ready) begin
        if (result_q.size() == 0) begin
          fails++;
          $display("%0t: unexpected result beat status=%0d value=%h",
                   $time, rsp_status, rsp_read_value);
        end else begin
          want = result_q.pop_front();
          checked++;
          if (rsp_status !== want.status) begin
            fails++;
            $display("%0t: status mismatch expected=%0d actual=%0d",
                     $time, want.status, rsp_status);
          end
          if (rsp_read_value !== want.read_value) begin
            fails++;
            $display("%0t: read_value mismatch expected=%h actual=%h",
                     $time, want.read_value, rsp_read_value);
          end
        end
      end
      if (cmd_valid && cmd_ready) begin
        want = apply_cmd(cmd_opcode, cmd_push_value);
        if (want.status == ST_FULL) fulls++;
        if (want.status == ST_EMPTY) empties++;
        result_q.push_back(want);
      end
    end
    fail_cnt    <= fails;
    pending_cnt <= result_q.size();
    checked_cnt <= checked;
    full_cnt    <= fulls;
    empty_cnt   <= empties;
  end

endmodule

>>> tb/double_ended_queue_unit_tb.sv
// Top of the double-ended queue unit testbench: clock, reset, command stimulus,
// result back-pressure and the verdict. Depends on deq_pkg, deq_if, the unit
// and double_ended_queue_unit_checker.
module double_ended_queue_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import deq_pkg::*;

  localparam int DEPTH        = 16;
  localparam int DATA_WIDTH   = 32;
  localparam int RANDOM_ITEMS = 700;
  localparam int HOLD_CYCLES  = 150;
  localparam int SEGMENT_LEN  = 30;
  localparam logic [OPCODE_W-1:0] OP_UNUSED = 3'd7;

  // push mix of a random segment
  localparam int LEAN_FILL    = 0;
  localparam int LEAN_DRAIN   = 1;
  localparam int LEAN_EVEN    = 2;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  deq_cmd_if in_cmd();
  deq_rsp_if out_rsp();

  int send_idle_pct;
  int recv_stall_pct;
  int hold_seq;
  int cmds_sent;
  int cmds_ignored;
  int fail_cnt;
  int pending_cnt;
  int checked_cnt;
  int full_cnt;
  int empty_cnt;

  double_ended_queue_unit #(
    .DEPTH     (DEPTH),
    .DATA_WIDTH(DATA_WIDTH)
  ) u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_cmd (in_cmd),
    .out_rsp(out_rsp)
  );

  double_ended_queue_unit_checker #(
    .DEPTH     (DEPTH),
    .DATA_WIDTH(DATA_WIDTH)
  ) u_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd_valid     (in_cmd.valid),
    .cmd_ready     (in_cmd.ready),
    .cmd_opcode    (in_cmd.opcode),
    .cmd_push_value(in_cmd.push_value),
    .rsp_valid     (out_rsp.valid),
    .rsp_ready     (out_rsp.ready),
    .rsp_status    (out_rsp.status),
    .rsp_read_value(out_rsp.read_value),
    .fail_cnt      (fail_cnt),
    .pending_cnt   (pending_cnt),
    .checked_cnt   (checked_cnt),
    .full_cnt      (full_cnt),
    .empty_cnt     (empty_cnt)
  );

  always #2 clk = ~clk;

  initial begin
    #2_000_000;
    $display("Some tests failed");
    $finish;
  end

  // Result side: random stalls, plus a long hold-off whenever hold_seq moves.
  initial begin : receiver
    int hold_left;
    int hold_seen;
    hold_left     = 0;
    hold_seen     = 0;
    out_rsp.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_seq != hold_seen) begin
        hold_seen = hold_seq;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left != 0) begin
        hold_left--;
        out_rsp.ready <= 1'b0;
      end else begin
        out_rsp.ready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  function automatic logic [OPCODE_W-1:0] pick_op(int lean);
    int roll     = $urandom_range(99);
    int push_pct = (lean == LEAN_FILL) ? 70 : (lean == LEAN_DRAIN) ? 20 : 45;
    if (roll < 2) return OP_CLEAR;
    if (roll < 4) return OP_UNUSED;
    if (roll < 4 + push_pct) return $urandom_range(1) ? OP_PUSH_FRONT : OP_PUSH_BACK;
    // pops and peeks are the four codes starting at pop front
    return OP_POP_FRONT + OPCODE_W'($urandom_range(3));
  endfunction

  function automatic logic [VALUE_W-1:0] pick_word();
    case ($urandom_range(9))
      0:       return '0;
      1:       return '1;
      default: return $urandom();
    endcase
  endfunction

  // One command beat; valid stays high into the next beat unless a gap is drawn.
  task automatic send_cmd(input logic [OPCODE_W-1:0] op, input logic [VALUE_W-1:0] word);
    while ($urandom_range(99) < send_idle_pct) begin
      in_cmd.valid <= 1'b0;
      @(posedge clk);
    end
    in_cmd.valid      <= 1'b1;
    in_cmd.opcode     <= op;
    in_cmd.push_value <= word;
    do @(posedge clk); while (in_cmd.ready !== 1'b1);
    cmds_sent++;
    if (op == OP_UNUSED) cmds_ignored++;
  endtask

  initial begin : stimulus
    int lean;
    int goal;
    in_cmd.valid      = 1'b0;
    in_cmd.opcode     = OP_PUSH_FRONT;
    in_cmd.push_value = '0;
    send_idle_pct     = 0;
    recv_stall_pct    = 0;
    hold_seq          = 0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // empty queue: every read reports an error
    send_cmd(OP_POP_FRONT, '0);
    send_cmd(OP_POP_BACK, '1);
    send_cmd(OP_PEEK_FRONT, '0);
    send_cmd(OP_PEEK_BACK, '1);
    // fill from both ends with extreme words, then push into a full queue
    for (int i = 0; i < DEPTH; i++) begin
      send_cmd((i % 2) ? OP_PUSH_BACK : OP_PUSH_FRONT,
               (i == 0) ? '0 : (i == 1) ? '1 : (i == 2) ? 32'hAAAA_AAAA :
               (i == 3) ? 32'h5555_5555 : $urandom());
    end
    send_cmd(OP_PUSH_FRONT, 32'h1234_5678);
    send_cmd(OP_PUSH_BACK, '1);
    send_cmd(OP_PEEK_FRONT, '0);
    send_cmd(OP_PEEK_BACK, '0);
    send_cmd(OP_POP_FRONT, '0);
    send_cmd(OP_POP_BACK, '0);
    send_cmd(OP_UNUSED, '1);
    send_cmd(OP_CLEAR, '0);
    send_cmd(OP_POP_BACK, '0);

    // back-pressure: result side holds off while commands keep coming
    hold_seq <= hold_seq + 1;
    for (int i = 0; i < 40; i++) send_cmd(pick_op(LEAN_FILL), pick_word());

    for (int phase = 0; phase < 4; phase++) begin
      send_idle_pct  = (phase == 1) ? 61 : (phase == 3) ? 34 : 0;
      recv_stall_pct <= (phase == 2) ? 61 : (phase == 3) ? 34 : 0;
      goal = (phase + 1) * RANDOM_ITEMS / 4;
      lean = LEAN_EVEN;
      while (cmds_sent - cmds_ignored < goal) begin
        if (cmds_sent % SEGMENT_LEN == 0) lean = $urandom_range(LEAN_EVEN);
        send_cmd(pick_op(lean), pick_word());
      end
    end

    in_cmd.valid <= 1'b0;
    @(posedge clk);
    while (pending_cnt != 0) @(posedge clk);
    repeat (DEPTH / 2 + 4) @(posedge clk);

    $display("Ran %0d commands (%0d unused opcode) over four idle/stall mixes, %0d results",
             cmds_sent, cmds_ignored, checked_cnt);
    $display("Saw %0d full rejects, %0d empty errors and a %0d-cycle result hold-off",
             full_cnt, empty_cnt, HOLD_CYCLES);
    if (fail_cnt == 0 && pending_cnt == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
